// ===== rtl/core/lookahead_heading_controller_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LOOKAHEAD_HEADING_CONTROLLER_CORE_DEFINES_SVH
`define LOOKAHEAD_HEADING_CONTROLLER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define LHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lhc_pkg.sv =====
package lhc_pkg;
	localparam int CordicSteps = 16;
	localparam int CordicMax   = 24;
	localparam int CordicN     = (CordicSteps > CordicMax) ? CordicMax : CordicSteps;
	localparam int StepW       = $clog2(CordicMax + 1);
	localparam int QueueDepth  = 2;
	localparam logic signed [17:0] AngPi     = 18'sd25736;
	localparam logic signed [17:0] AngHalfPi = 18'sd12868;

	typedef enum logic [1:0] {
		REQ_POSE  = 2'd0,
		REQ_POINT = 2'd1,
		REQ_GOAL  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_LOOKAHEAD = 2'd0,
		CFG_GOAL_TOL  = 2'd1,
		CFG_LIN_SPEED = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_YAW = 2'd0,
		OP_CMD = 2'd1,
		OP_GOAL = 2'd2
	} op_t;

	// work handed from front to back end
	typedef struct packed {
		op_t                op;
		logic signed [47:0] vec_x;
		logic signed [47:0] vec_y;
		logic               fallback;
		logic               goal_hit;
	} job_t;

	function automatic logic signed [17:0] atan_lut(input logic [StepW-1:0] i);
		logic signed [17:0] r;
		case (i)
			5'd0:  r = 18'sd6434;
			5'd1:  r = 18'sd3798;
			5'd2:  r = 18'sd2007;
			5'd3:  r = 18'sd1019;
			5'd4:  r = 18'sd511;
			5'd5:  r = 18'sd256;
			5'd6:  r = 18'sd128;
			5'd7:  r = 18'sd64;
			5'd8:  r = 18'sd32;
			5'd9:  r = 18'sd16;
			5'd10: r = 18'sd8;
			5'd11: r = 18'sd4;
			5'd12: r = 18'sd2;
			5'd13: r = 18'sd1;
			default: r = 18'sd0;
		endcase
		return r;
	endfunction
endpackage

// ===== rtl/core/lhc_front.sv =====
// Front end: pose capture, yaw vector, squared distance, target latch, goal compare.
module lhc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [15:0]  quat_x,
	input  logic signed [15:0]  quat_y,
	input  logic signed [15:0]  quat_z,
	input  logic signed [15:0]  quat_w,
	input  logic                last_point,
	input  logic [30:0]         lookahead,
	input  logic [30:0]         goal_tolerance,
	output logic                job_valid,
	output lhc_pkg::job_t       job,
	input  logic                job_full
);
	import lhc_pkg::*;

	// stage 1: captured item plus differences and quaternion products
	logic               busy_q;
	logic [1:0]         req_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [31:0] px_s1, py_s1;
	logic               last_s1;
	logic signed [31:0] p_wz_s1, p_xy_s1, p_yy_s1, p_zz_s1;
	logic signed [31:0] robot_x_q, robot_y_q, target_x_q, target_y_q;
	logic               found_q;
	logic [63:0]        l2_q, t2_q;

	assign in_stall = busy_q || job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= in_valid && !in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1  <= req_type;
			px_s1   <= pos_x;
			py_s1   <= pos_y;
			last_s1 <= last_point;
			dx_s1   <= 33'(pos_x) - 33'(robot_x_q);
			dy_s1   <= 33'(pos_y) - 33'(robot_y_q);
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_yy_s1 <= quat_y * quat_y;
			p_zz_s1 <= quat_z * quat_z;
		end
		l2_q <= 64'(lookahead) * 64'(lookahead);
		t2_q <= 64'(goal_tolerance) * 64'(goal_tolerance);
	end

	// squares: magnitude of a 33-bit difference, saturate at or above 2^32
	logic [32:0] ax, ay;
	logic [63:0] sx, sy, dsum;
	logic [64:0] raw;
	assign ax = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign ay = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
	assign sx = ax[32] ? '1 : 64'(ax[31:0]) * 64'(ax[31:0]);
	assign sy = ay[32] ? '1 : 64'(ay[31:0]) * 64'(ay[31:0]);
	assign raw = 65'(sx) + 65'(sy);
	assign dsum = raw[64] ? '1 : raw[63:0];

	logic               hit;
	logic signed [31:0] tx, ty;
	logic               fb;
	always_comb begin
		hit = !found_q && (dsum > l2_q);
		tx = hit ? px_s1 : target_x_q;
		ty = hit ? py_s1 : target_y_q;
		fb = !(found_q || hit);
		if (fb) begin
			tx = px_s1;
			ty = py_s1;
		end
		job = '0;
		job_valid = 1'b0;
		case (req_t'(req_s1))
			REQ_POSE: begin
				job_valid = busy_q;
				job.op = OP_YAW;
				job.vec_x = 48'sd268435456 - ((48'(p_yy_s1) + 48'(p_zz_s1)) <<< 1);
				job.vec_y = (48'(p_wz_s1) + 48'(p_xy_s1)) <<< 1;
			end
			REQ_POINT: begin
				job_valid = busy_q && last_s1;
				job.op = OP_CMD;
				job.vec_x = 48'(33'(tx) - 33'(robot_x_q));
				job.vec_y = 48'(33'(ty) - 33'(robot_y_q));
				job.fallback = fb;
			end
			REQ_GOAL: begin
				job_valid = busy_q;
				job.op = OP_GOAL;
				job.goal_hit = dsum < t2_q;
			end
			default: job_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q <= '0;
			robot_y_q <= '0;
			target_x_q <= '0;
			target_y_q <= '0;
			found_q <= 1'b0;
		end else if (busy_q) begin
			case (req_t'(req_s1))
				REQ_POSE: begin
					robot_x_q <= px_s1;
					robot_y_q <= py_s1;
					found_q <= 1'b0;
				end
				REQ_POINT: begin
					if (hit) begin
						target_x_q <= px_s1;
						target_y_q <= py_s1;
					end
					found_q <= last_s1 ? 1'b0 : (found_q || hit);
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/core/lhc_queue.sv =====
// Small FIFO between front and back.
module lhc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  lhc_pkg::job_t wr_data,
	output logic          full,
	output logic          rd_valid,
	input  logic          rd_en,
	output lhc_pkg::job_t rd_data
);
	import lhc_pkg::*;
	localparam int AW = $clog2(QueueDepth);
	job_t          mem_q [QueueDepth];
	logic [AW:0]   wp_q, rp_q;

	// full leaves one slot for the job still in the front stage
	assign full = (wp_q - rp_q) >= (AW + 1)'(QueueDepth - 1);
	assign rd_valid = wp_q != rp_q;
	assign rd_data = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q[AW-1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

// ===== rtl/core/lhc_back.sv =====
// Back end: iterative CORDIC atan2, heading error, output register.
module lhc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  lhc_pkg::job_t       job,
	output logic                job_take,
	input  logic [30:0]         linear_speed,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [30:0]         linear_cmd,
	output logic signed [15:0]  angular_cmd,
	output logic                goal_reached,
	output logic                used_fallback
);
	import lhc_pkg::*;

	logic               run_q;
	logic [StepW-1:0]   step_q;
	op_t                op_q;
	logic               fb_q;
	logic signed [49:0] x_q, y_q;
	logic signed [17:0] z_q, yaw_q;
	logic               done;

	// goal jobs need room in the output register
	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign job_take = job_valid && !run_q && (job.op == OP_CMD || job.op == OP_YAW || out_free)
		&& (job.op != OP_GOAL || out_free);
	assign done = run_q && (step_q == StepW'(CordicN)) && (op_q == OP_YAW || out_free);

	// pre-rotation when x < 0
	logic signed [49:0] x0, y0;
	logic signed [17:0] z0;
	always_comb begin
		x0 = 50'(job.vec_x);
		y0 = 50'(job.vec_y);
		z0 = '0;
		if (job.vec_x < 0) begin
			if (job.vec_y >= 0) begin
				z0 = AngHalfPi;
				x0 = 50'(job.vec_y);
				y0 = -50'(job.vec_x);
			end else begin
				z0 = -AngHalfPi;
				x0 = -50'(job.vec_y);
				y0 = 50'(job.vec_x);
			end
		end
	end

	// final angle, clamp, error wrap, 3/4 rounding
	logic signed [17:0] zc;
	logic signed [19:0] err, v;
	logic signed [15:0] ang;
	always_comb begin
		zc = z_q;
		if (z_q > AngPi) zc = AngPi;
		if (z_q < -AngPi) zc = -AngPi;
		err = 20'(zc) - 20'(yaw_q);
		if (err > 20'(AngPi)) err = err - 20'(2 * AngPi);
		if (err < -20'(AngPi)) err = err + 20'(2 * AngPi);
		v = 20'(3) * err + 20'sd2;
		ang = 16'(v >>> 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			yaw_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if ((job_take && job.op == OP_GOAL) || (done && op_q == OP_CMD)) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (job_take && job.op != OP_GOAL) begin
				run_q <= 1'b1;
			end else if (done) begin
				run_q <= 1'b0;
			end
			if (done && op_q == OP_YAW) yaw_q <= zc;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			op_q <= job.op;
			fb_q <= job.fallback;
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
			// zero vector: skip the iterations, angle stays 0
			step_q <= (job.vec_x == 0 && job.vec_y == 0) ? StepW'(CordicN) : '0;
			if (job.op == OP_GOAL) begin
				result_kind <= 1'b1;
				linear_cmd <= '0;
				angular_cmd <= '0;
				goal_reached <= job.goal_hit;
				used_fallback <= 1'b0;
			end
		end else if (run_q && step_q != StepW'(CordicN)) begin
			step_q <= step_q + 1'b1;
			if (y_q >= 0) begin
				x_q <= x_q + (y_q >>> step_q);
				y_q <= y_q - (x_q >>> step_q);
				z_q <= z_q + atan_lut(step_q);
			end else begin
				x_q <= x_q - (y_q >>> step_q);
				y_q <= y_q + (x_q >>> step_q);
				z_q <= z_q - atan_lut(step_q);
			end
		end
		if (done && op_q == OP_CMD) begin
			result_kind <= 1'b0;
			linear_cmd <= linear_speed;
			angular_cmd <= ang;
			goal_reached <= 1'b0;
			used_fallback <= fb_q;
		end
	end
endmodule

// ===== rtl/core/lookahead_heading_controller_core.sv =====
// A goal status passes the front stage, the queue and the output register; a last path
// point passes the front, the queue and a 16-step CORDIC pass, which is skipped when
// the target vector is zero. Pose items give no result. The front end stalls its
// input while an accepted item is in stage 1; an item that makes a job holds the
// input until the back end takes it; a CORDIC job keeps the back end busy until
// its result is written. Reset: arst_n clears pose, yaw, target, queue, CORDIC control
// and output valid, and loads register defaults.
module lookahead_heading_controller_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic               last_point,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [30:0]        linear_cmd,
	output logic signed [15:0] angular_cmd,
	output logic               goal_reached,
	output logic               used_fallback
);
	import lhc_pkg::*;

	// configuration registers; writes are always taken
	logic [30:0] lookahead_q, goal_tol_q, lin_speed_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookahead_q <= 31'd65536;
			goal_tol_q  <= 31'd6554;
			lin_speed_q <= 31'd32768;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LOOKAHEAD: lookahead_q <= cfg_data;
				CFG_GOAL_TOL:  goal_tol_q  <= cfg_data;
				CFG_LIN_SPEED: lin_speed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front to back transfer through the queue
	logic job_wr, q_full, q_valid, q_take;
	job_t job_in, job_out;

	lhc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .pos_x, .pos_y,
		.quat_x, .quat_y, .quat_z, .quat_w, .last_point,
		.lookahead(lookahead_q), .goal_tolerance(goal_tol_q),
		.job_valid(job_wr), .job(job_in), .job_full(q_full)
	);

	lhc_queue u_queue (
		.clk, .arst_n, .wr_en(job_wr), .wr_data(job_in), .full(q_full),
		.rd_valid(q_valid), .rd_en(q_take), .rd_data(job_out)
	);

	lhc_back u_back (
		.clk, .arst_n, .job_valid(q_valid), .job(job_out), .job_take(q_take),
		.linear_speed(lin_speed_q), .out_valid, .out_stall, .result_kind,
		.linear_cmd, .angular_cmd, .goal_reached, .used_fallback
	);
endmodule

// ===== rtl/core/lhc_checker.sv =====
`include "lookahead_heading_controller_core_defines.svh"
module lhc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        result_kind,
	input logic [30:0] linear_cmd,
	input logic [15:0] angular_cmd,
	input logic        goal_reached,
	input logic        used_fallback
);
	`LHC_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(angular_cmd), "held result changed")
	`LHC_ASSERT_IMP(a_goal_zero, clk, arst_n, out_valid && result_kind, linear_cmd == 31'd0 && angular_cmd == 16'd0 && !used_fallback, "goal status carries command data")
	`LHC_ASSERT_IMP(a_cmd_flag, clk, arst_n, out_valid && !result_kind, !goal_reached, "command carries goal flag")
endmodule

bind lookahead_heading_controller_core lhc_checker u_lhc_checker (
	.clk, .arst_n, .out_valid, .out_stall, .result_kind, .linear_cmd,
	.angular_cmd, .goal_reached, .used_fallback
);
